// ----- sv/l3d_pkg.sv -----
`timescale 1ns / 1ps

package l3d_pkg;

    // Fixed field widths
    localparam int FIELD_BITS    = 16;
    localparam int DEPTH_BITS    = 5;
    localparam int GRID_BITS     = 6;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 6;

    // Q0.16 fractions and weights, one extra bit to hold exactly one
    localparam int FRAC_BITS = 16;
    localparam int WGT_BITS  = FRAC_BITS + 1;
    localparam logic [WGT_BITS-1:0] ONE_Q16 = 17'h10000;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_BIT_DEPTH = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_GRID_SIZE = 1'b1;

    // Register reset values
    localparam logic [DEPTH_BITS-1:0] DEPTH_RESET = 5'd10;
    localparam logic [GRID_BITS-1:0]  GRID_RESET  = 6'd33;

    // Request kinds
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    typedef logic [WGT_BITS-1:0] frac_t;

    typedef struct packed {
        frac_t w0;
        frac_t w1;
        frac_t w2;
        frac_t w3;
    } weight_t;

    // Tetrahedron, named by descending fraction order
    typedef enum logic [2:0] {
        TET_XYZ,
        TET_XZY,
        TET_ZXY,
        TET_ZYX,
        TET_YZX,
        TET_YXZ
    } tet_t;

endpackage

// ----- sv/l3d_ram.sv -----
`timescale 1ns / 1ps

// Simple RAM: one write port, two registered read ports
module l3d_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 35937
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ----- sv/l3d_div.sv -----
`timescale 1ns / 1ps

// Pipelined restoring divider: (num << 16) / maxv, one quotient bit per stage.
// Quotient high bits are the cell index, low 16 bits the fraction.
module l3d_div #(
    parameter int CB = 16,
    parameter int IW = 6
) (
    input  logic                                 clk,
    input  logic [IW+l3d_pkg::FRAC_BITS-1:0]     en,
    input  logic [CB+IW-1:0]                     num,
    input  logic [CB-1:0]                        maxv,
    output logic [IW+l3d_pkg::FRAC_BITS-1:0]     quo
);

    localparam int QW = IW + l3d_pkg::FRAC_BITS;
    localparam int NW = CB + IW;

    logic [CB-1:0] rem_reg [QW];
    logic [NW-1:0] num_reg [QW];
    logic [QW-1:0] quo_reg [QW];

    for (genvar j = 0; j < QW; j++)
    begin : g_stage
        localparam int POS = QW - 1 - j;

        logic [CB-1:0] rem_in;
        logic [NW-1:0] num_in;
        logic [QW-1:0] quo_in;
        logic          bit_in;
        logic [CB:0]   trial;
        logic          ge;
        logic [CB-1:0] rem_next;
        logic [QW-1:0] quo_next;

        if (j == 0)
        begin : g_first
            // numerator >> QW is below the divisor, so it seeds the remainder
            assign rem_in = num[NW-1:IW];
            assign num_in = num;
            assign quo_in = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[j-1];
            assign num_in = num_reg[j-1];
            assign quo_in = quo_reg[j-1];
        end

        // Numerator bit brought down at this step; the low 16 are zero
        if (POS >= l3d_pkg::FRAC_BITS)
        begin : g_bit
            assign bit_in = num_in[POS-l3d_pkg::FRAC_BITS];
        end
        else
        begin : g_zero
            assign bit_in = 1'b0;
        end

        // Compare and subtract
        always_comb
        begin
            trial = {rem_in, bit_in};
            ge    = (trial >= {1'b0, maxv});
            if (ge)
            begin
                rem_next = CB'(trial - {1'b0, maxv});
            end
            else
            begin
                rem_next = CB'(trial);
            end
            quo_next      = quo_in;
            quo_next[POS] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                quo_reg[j] <= quo_next;
            end
        end

        if (j < QW - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en[j])
                begin
                    rem_reg[j] <= rem_next;
                    num_reg[j] <= num_in;
                end
            end
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

// ----- sv/l3d_blend.sv -----
`timescale 1ns / 1ps

// One channel of the corner blend: products, then sum, shift and clamp
module l3d_blend #(
    parameter int CB = 16
) (
    input  logic              clk,
    input  logic              en_mul,
    input  logic              en_sum,
    input  l3d_pkg::weight_t  wts,
    input  logic [CB-1:0]     e0,
    input  logic [CB-1:0]     e1,
    input  logic [CB-1:0]     e2,
    input  logic [CB-1:0]     e3,
    input  logic [CB-1:0]     maxv,
    output logic [CB-1:0]     res
);

    localparam int PW = CB + l3d_pkg::WGT_BITS;
    localparam int SW = PW + 2;
    localparam int HW = SW - l3d_pkg::FRAC_BITS;

    logic [PW-1:0] prod_reg [4];
    logic [SW-1:0] sum;
    logic [HW-1:0] sum_hi;
    logic [CB-1:0] res_next;
    logic [CB-1:0] res_reg;

    // Weight times corner value
    always_ff @(posedge clk)
    begin
        if (en_mul)
        begin
            prod_reg[0] <= PW'(wts.w0) * PW'(e0);
            prod_reg[1] <= PW'(wts.w1) * PW'(e1);
            prod_reg[2] <= PW'(wts.w2) * PW'(e2);
            prod_reg[3] <= PW'(wts.w3) * PW'(e3);
        end
    end

    // Sum, drop the fraction, saturate to the code range
    always_comb
    begin
        sum = SW'(prod_reg[0]) + SW'(prod_reg[1]) + SW'(prod_reg[2]) + SW'(prod_reg[3]);
        sum_hi = sum[SW-1:l3d_pkg::FRAC_BITS];
        if (sum_hi > HW'(maxv))
        begin
            res_next = maxv;
        end
        else
        begin
            res_next = CB'(sum_hi);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_sum)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ----- sv/lut3d_tetrahedral_interp.sv -----
`timescale 1ns / 1ps

// Channel   Handshake            Payload
// in        in_valid / in_stall  req_type, entry_index, entry_r/g/b, pixel_r/g/b
// out       out_valid / out_stall out_r, out_g, out_b (one per pixel item)
// cfg       cfg_we               cfg_index, cfg_data (no read-back)
//
// One item per cycle while in_stall is low. A pixel result passes the input, scale,
// divider, fix, tetrahedron, address, read, multiply and sum stages; the divider
// yields one quotient bit per stage. The four corners are read in the same cycle from
// two dual-read copies of the table. Reset clears control only; table contents
// are undefined until loaded. Stalls collapse bubbles; in_stall rises only when
// every stage holds an item and out_stall is high.
module lut3d_tetrahedral_interp #(
    parameter int MAX_GRID     = 33,
    parameter int CHANNEL_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               cfg_we,
    input  logic [l3d_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [l3d_pkg::CFG_DATA_BITS-1:0]  cfg_data,

    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               req_type,
    input  logic [15:0]                        entry_index,
    input  logic [15:0]                        entry_r,
    input  logic [15:0]                        entry_g,
    input  logic [15:0]                        entry_b,
    input  logic [15:0]                        pixel_r,
    input  logic [15:0]                        pixel_g,
    input  logic [15:0]                        pixel_b,

    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [15:0]                        out_r,
    output logic [15:0]                        out_g,
    output logic [15:0]                        out_b
);

    localparam int CB        = CHANNEL_BITS;
    localparam int IW        = $clog2(MAX_GRID);
    localparam int GW        = $clog2(MAX_GRID + 1);
    localparam int LUT_DEPTH = MAX_GRID * MAX_GRID * MAX_GRID;
    localparam int AW        = $clog2(LUT_DEPTH);
    localparam int FB        = l3d_pkg::FRAC_BITS;
    localparam int QW        = IW + FB;
    localparam int NW        = CB + IW;
    localparam int EW        = 3 * CB;

    // Stage numbers
    localparam int S_IN  = 0;
    localparam int S_NUM = 1;
    localparam int S_DIV = 2;
    localparam int S_FIX = S_DIV + QW;
    localparam int S_TET = S_FIX + 1;
    localparam int S_ADR = S_TET + 1;
    localparam int S_RD  = S_ADR + 1;
    localparam int S_MUL = S_RD + 1;
    localparam int S_SUM = S_MUL + 1;
    localparam int NSTG  = S_SUM + 1;

    // ------------------------------------------------------------------
    // Configuration registers and derived values
    // ------------------------------------------------------------------
    logic [l3d_pkg::DEPTH_BITS-1:0] bit_depth_reg;
    logic [l3d_pkg::GRID_BITS-1:0]  grid_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_depth_reg <= l3d_pkg::DEPTH_RESET;
            grid_size_reg <= l3d_pkg::GRID_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                l3d_pkg::REG_BIT_DEPTH: bit_depth_reg <= cfg_data[l3d_pkg::DEPTH_BITS-1:0];
                l3d_pkg::REG_GRID_SIZE: grid_size_reg <= cfg_data[l3d_pkg::GRID_BITS-1:0];
            endcase
        end
    end

    logic [4:0]    d_eff;
    logic [4:0]    shamt;
    logic [6:0]    g_eff;
    logic [CB-1:0] maxv_next, maxv_reg;
    logic [GW-1:0] g_next, g_reg;
    logic [IW-1:0] s_next, s_reg;
    logic [IW-1:0] gm2_next, gm2_reg;
    logic [AW-1:0] gsq_next, gsq_reg;
    logic [AW-1:0] s3_next, s3_reg;

    // Clamp depth and grid, then form 2^d-1, g-1, g-2, g^2, 1+g+g^2
    always_comb
    begin
        if (bit_depth_reg == 5'd0)
        begin
            d_eff = 5'd1;
        end
        else if (bit_depth_reg > 5'(CB))
        begin
            d_eff = 5'(CB);
        end
        else
        begin
            d_eff = bit_depth_reg;
        end
        shamt     = 5'(CB) - d_eff;
        maxv_next = {CB{1'b1}} >> shamt;

        if ({1'b0, grid_size_reg} < 7'd2)
        begin
            g_eff = 7'd2;
        end
        else if ({1'b0, grid_size_reg} > 7'(MAX_GRID))
        begin
            g_eff = 7'(MAX_GRID);
        end
        else
        begin
            g_eff = {1'b0, grid_size_reg};
        end
        g_next   = GW'(g_eff);
        s_next   = IW'(g_eff - 7'd1);
        gm2_next = IW'(g_eff - 7'd2);
        gsq_next = AW'(g_reg) * AW'(g_reg);
        s3_next  = AW'(1) + AW'(g_reg) + gsq_reg;
    end

    always_ff @(posedge clk)
    begin
        maxv_reg <= maxv_next;
        g_reg    <= g_next;
        s_reg    <= s_next;
        gm2_reg  <= gm2_next;
        gsq_reg  <= gsq_next;
        s3_reg   <= s3_next;
    end

    // Item kind and write payload, carried up to the address stage
    logic          pix_reg  [S_ADR+1];
    logic [15:0]   widx_reg [S_ADR+1];
    logic [EW-1:0] went_reg [S_ADR+1];
    logic [15:0]   px_reg   [3];

    // ------------------------------------------------------------------
    // Pipeline control: a stage loads when empty or when the next one loads
    // ------------------------------------------------------------------
    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] en;

    for (genvar k = 0; k < NSTG; k++)
    begin : g_en
        assign en[k] = !((&v_reg[NSTG-1:k]) && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NSTG; k++)
            begin
                if (en[k])
                begin
                    if (k == S_IN)
                    begin
                        v_reg[k] <= in_valid;
                    end
                    else if (k == S_RD)
                    begin
                        // table writes end at the read stage
                        v_reg[k] <= v_reg[k-1] && (pix_reg[S_ADR] == l3d_pkg::REQ_PIXEL);
                    end
                    else
                    begin
                        v_reg[k] <= v_reg[k-1];
                    end
                end
            end
        end
    end

    assign in_stall  = !en[S_IN];
    assign out_valid = v_reg[NSTG-1];

    // ------------------------------------------------------------------
    // Item kind and write payload, carried up to the address stage
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (en[S_IN])
        begin
            pix_reg[S_IN]  <= req_type;
            widx_reg[S_IN] <= entry_index;
            went_reg[S_IN] <= {CB'(entry_b), CB'(entry_g), CB'(entry_r)};
            px_reg[0]      <= pixel_r;
            px_reg[1]      <= pixel_g;
            px_reg[2]      <= pixel_b;
        end
        for (int k = 1; k <= S_ADR; k++)
        begin
            if (en[k])
            begin
                pix_reg[k]  <= pix_reg[k-1];
                widx_reg[k] <= widx_reg[k-1];
                went_reg[k] <= went_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Saturate pixel channels and scale by g-1
    // ------------------------------------------------------------------
    logic [CB-1:0] psat [3];
    logic [NW-1:0] num_reg [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (px_reg[c] > 16'(maxv_reg))
            begin
                psat[c] = maxv_reg;
            end
            else
            begin
                psat[c] = CB'(px_reg[c]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S_NUM])
        begin
            for (int c = 0; c < 3; c++)
            begin
                num_reg[c] <= NW'(psat[c]) * NW'(s_reg);
            end
        end
    end

    // ------------------------------------------------------------------
    // Divide by 2^d-1 into cell index and fraction
    // ------------------------------------------------------------------
    logic [QW-1:0] quo [3];

    for (genvar c = 0; c < 3; c++)
    begin : g_div
        l3d_div #(
            .CB (CB),
            .IW (IW)
        ) u_div (
            .clk  (clk),
            .en   (en[S_DIV +: QW]),
            .num  (num_reg[c]),
            .maxv (maxv_reg),
            .quo  (quo[c])
        );
    end

    // Full-scale channel: step back one cell with fraction one
    logic [IW-1:0]        idx_reg  [3];
    l3d_pkg::frac_t       frac_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[S_FIX])
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (quo[c][QW-1:FB] >= s_reg)
                begin
                    idx_reg[c]  <= gm2_reg;
                    frac_reg[c] <= l3d_pkg::ONE_Q16;
                end
                else
                begin
                    idx_reg[c]  <= quo[c][QW-1:FB];
                    frac_reg[c] <= {1'b0, quo[c][FB-1:0]};
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tetrahedron select, weights, corner offsets, partial addresses
    // ------------------------------------------------------------------
    l3d_pkg::tet_t    tet;
    l3d_pkg::frac_t   fx, fy, fz;
    l3d_pkg::weight_t wts_next;
    logic [AW-1:0]    oy, oz;
    logic [AW-1:0]    off1_next, off2_next;

    always_comb
    begin
        fx = frac_reg[0];
        fy = frac_reg[1];
        fz = frac_reg[2];
        oy = AW'(g_reg);
        oz = gsq_reg;

        // ties resolve in comparison order
        if (fx > fy)
        begin
            priority if (fy > fz) tet = l3d_pkg::TET_XYZ;
            else if (fx > fz)     tet = l3d_pkg::TET_XZY;
            else                  tet = l3d_pkg::TET_ZXY;
        end
        else
        begin
            priority if (fz > fy) tet = l3d_pkg::TET_ZYX;
            else if (fz > fx)     tet = l3d_pkg::TET_YZX;
            else                  tet = l3d_pkg::TET_YXZ;
        end

        unique case (tet)
            l3d_pkg::TET_XYZ:
            begin
                wts_next  = '{l3d_pkg::ONE_Q16 - fx, fx - fy, fy - fz, fz};
                off1_next = AW'(1);
                off2_next = AW'(1) + oy;
            end
            l3d_pkg::TET_XZY:
            begin
                wts_next  = '{l3d_pkg::ONE_Q16 - fx, fx - fz, fz - fy, fy};
                off1_next = AW'(1);
                off2_next = AW'(1) + oz;
            end
            l3d_pkg::TET_ZXY:
            begin
                wts_next  = '{l3d_pkg::ONE_Q16 - fz, fz - fx, fx - fy, fy};
                off1_next = oz;
                off2_next = oz + AW'(1);
            end
            l3d_pkg::TET_ZYX:
            begin
                wts_next  = '{l3d_pkg::ONE_Q16 - fz, fz - fy, fy - fx, fx};
                off1_next = oz;
                off2_next = oz + oy;
            end
            l3d_pkg::TET_YZX:
            begin
                wts_next  = '{l3d_pkg::ONE_Q16 - fy, fy - fz, fz - fx, fx};
                off1_next = oy;
                off2_next = oy + oz;
            end
            default:
            begin
                wts_next  = '{l3d_pkg::ONE_Q16 - fy, fy - fx, fx - fz, fz};
                off1_next = oy;
                off2_next = oy + AW'(1);
            end
        endcase
    end

    l3d_pkg::weight_t wts_t_reg;
    logic [AW-1:0]    ix_reg, py_reg, pz_reg, off1_reg, off2_reg;

    always_ff @(posedge clk)
    begin
        if (en[S_TET])
        begin
            wts_t_reg <= wts_next;
            off1_reg  <= off1_next;
            off2_reg  <= off2_next;
            ix_reg    <= AW'(idx_reg[0]);
            py_reg    <= AW'(idx_reg[1]) * AW'(g_reg);
            pz_reg    <= AW'(idx_reg[2]) * gsq_reg;
        end
    end

    // Corner addresses
    logic [AW-1:0]    adr_reg [4];
    l3d_pkg::weight_t wts_a_reg;

    always_ff @(posedge clk)
    begin
        if (en[S_ADR])
        begin
            adr_reg[0] <= pz_reg + py_reg + ix_reg;
            adr_reg[1] <= pz_reg + py_reg + ix_reg + off1_reg;
            adr_reg[2] <= pz_reg + py_reg + ix_reg + off2_reg;
            adr_reg[3] <= pz_reg + py_reg + ix_reg + s3_reg;
            wts_a_reg  <= wts_t_reg;
        end
    end

    // ------------------------------------------------------------------
    // Table: two copies, each read at two corners; writes land in order
    // ------------------------------------------------------------------
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [EW-1:0]    rd [4];
    l3d_pkg::weight_t wts_b_reg;

    assign ram_we = en[S_RD] && v_reg[S_ADR] && (pix_reg[S_ADR] == l3d_pkg::REQ_WRITE)
                    && ({16'd0, widx_reg[S_ADR]} < 32'(LUT_DEPTH));
    assign ram_waddr = AW'(widx_reg[S_ADR]);

    l3d_ram #(
        .WIDTH (EW),
        .DEPTH (LUT_DEPTH)
    ) u_ram_lo (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (went_reg[S_ADR]),
        .re      (en[S_RD]),
        .raddr_a (adr_reg[0]),
        .raddr_b (adr_reg[1]),
        .rdata_a (rd[0]),
        .rdata_b (rd[1])
    );

    l3d_ram #(
        .WIDTH (EW),
        .DEPTH (LUT_DEPTH)
    ) u_ram_hi (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (went_reg[S_ADR]),
        .re      (en[S_RD]),
        .raddr_a (adr_reg[2]),
        .raddr_b (adr_reg[3]),
        .rdata_a (rd[2]),
        .rdata_b (rd[3])
    );

    always_ff @(posedge clk)
    begin
        if (en[S_RD])
        begin
            wts_b_reg <= wts_a_reg;
        end
    end

    // ------------------------------------------------------------------
    // Blend per channel
    // ------------------------------------------------------------------
    logic [CB-1:0] res [3];

    for (genvar c = 0; c < 3; c++)
    begin : g_blend
        l3d_blend #(
            .CB (CB)
        ) u_blend (
            .clk    (clk),
            .en_mul (en[S_MUL]),
            .en_sum (en[S_SUM]),
            .wts    (wts_b_reg),
            .e0     (rd[0][c*CB +: CB]),
            .e1     (rd[1][c*CB +: CB]),
            .e2     (rd[2][c*CB +: CB]),
            .e3     (rd[3][c*CB +: CB]),
            .maxv   (maxv_reg),
            .res    (res[c])
        );
    end

    assign out_r = 16'(res[0]);
    assign out_g = 16'(res[1]);
    assign out_b = 16'(res[2]);

endmodule

// ----- sv/l3d_chk.sv -----
`timescale 1ns / 1ps

// Port-level checks for the LUT interpolator
module l3d_chk (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_stall,
    input logic                               req_type,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic [15:0]                        out_r,
    input logic [15:0]                        out_g,
    input logic [15:0]                        out_b
);

    logic        pix_acc;
    logic        out_acc;
    logic [15:0] pending_reg;

    assign pix_acc = in_valid && !in_stall && (req_type == l3d_pkg::REQ_PIXEL);
    assign out_acc = out_valid && !out_stall;

    // Pixel items in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 16'(pix_acc) - 16'(out_acc);
        end
    end

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_r) && $stable(out_g)
                                   && $stable(out_b))
        else $error("stalled result changed");

    // Input backs up only when the output is blocked
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output free");

    // Every result answers a pixel item
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 16'd0)
        else $error("result without pending pixel");

endmodule

bind lut3d_tetrahedral_interp l3d_chk u_l3d_chk (.*);
